// ----- src/pnc_pkg.sv -----
package pnc_pkg;

  localparam int unsigned ACTIONS = 8;
  localparam int unsigned ACT_W   = 3;
  localparam int unsigned PAY_W   = 32;
  localparam int unsigned IDX_W   = $clog2(ACTIONS);
  localparam int unsigned CELLS   = ACTIONS * ACTIONS * ACTIONS;
  localparam int unsigned ADDR_W  = $clog2(CELLS);

  localparam int unsigned IN_DATA_W  = ((3 * ACT_W + 3 * PAY_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((1 + 3 * PAY_W + 7) / 8) * 8;

  typedef logic [ACT_W-1:0]         act_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic signed [PAY_W-1:0]  pay_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // control of the shared compare unit
  typedef struct packed {
    logic clear;
    logic load_own;
    logic compare;
  } cmp_ctl_t;

  function automatic logic act_in_range(act_t a);
    return 32'(a) < 32'(ACTIONS);
  endfunction

  function automatic idx_t act_idx(act_t a);
    return IDX_W'(a);
  endfunction

  function automatic addr_t cell_addr(idx_t a, idx_t b, idx_t c);
    return ADDR_W'((32'(a) * 32'(ACTIONS) + 32'(b)) * 32'(ACTIONS) + 32'(c));
  endfunction

endpackage

// ----- src/pnc_ram.sv -----
module pnc_ram
  import pnc_pkg::*;
(
  input  logic  clk_i,
  input  logic  we_i,
  input  addr_t waddr_i,
  input  pay_t  wdata_i,
  input  logic  re_i,
  input  addr_t raddr_i,
  output pay_t  rdata_o
);

  pay_t mem [CELLS];
  pay_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/pnc_cmp.sv -----
module pnc_cmp
  import pnc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cmp_ctl_t ctl_i,
  input  pay_t     rd_first_i,
  input  pay_t     rd_second_i,
  input  pay_t     rd_third_i,
  output pay_t     own_first_o,
  output pay_t     own_second_o,
  output pay_t     own_third_o,
  output logic     eq_o
);

  pay_t own_first_q, own_second_q, own_third_q;
  logic eq_acc_q, eq_acc_d;
  logic gain;

  // any player strictly better off in the deviation cell just read
  assign gain = (rd_first_i > own_first_q) || (rd_second_i > own_second_q)
             || (rd_third_i > own_third_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_own) begin
      own_first_q  <= rd_first_i;
      own_second_q <= rd_second_i;
      own_third_q  <= rd_third_i;
    end
  end

  always_comb begin
    eq_acc_d = eq_acc_q;
    if (ctl_i.clear) begin
      eq_acc_d = 1'b1;
    end else if (ctl_i.compare) begin
      eq_acc_d = eq_acc_q && !gain;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eq_acc_q <= 1'b1;
    end else begin
      eq_acc_q <= eq_acc_d;
    end
  end

  assign own_first_o  = own_first_q;
  assign own_second_o = own_second_q;
  assign own_third_o  = own_third_q;
  assign eq_o         = eq_acc_q && !gain;

  a_clear_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.clear |=> eq_acc_q)
    else $error("equilibrium flag not set after clear");

endmodule

// ----- src/pnc_ctrl.sv -----
module pnc_ctrl
  import pnc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     op_i,
  input  act_t     act_first_i,
  input  act_t     act_second_i,
  input  act_t     act_third_i,
  output logic     mem_we_o,
  output addr_t    mem_waddr_o,
  output logic     mem_re_o,
  output addr_t    raddr_first_o,
  output addr_t    raddr_second_o,
  output addr_t    raddr_third_o,
  output cmp_ctl_t cmp_ctl_o,
  input  logic     cmp_eq_i,
  input  pay_t     own_first_i,
  input  pay_t     own_second_i,
  input  pay_t     own_third_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output logic     out_eq_o,
  output pay_t     out_pay_first_o,
  output pay_t     out_pay_second_o,
  output pay_t     out_pay_third_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_OWN  = 4'b0010,
    ST_DEV  = 4'b0100,
    ST_LAST = 4'b1000
  } state_e;

  state_e state_q, state_d;
  idx_t   cnt_q, cnt_d;
  idx_t   x_q, y_q, z_q;
  logic   bad_q, bad_d;
  logic   out_valid_q, out_valid_d;
  logic   out_eq_q;
  pay_t   out_pay_first_q, out_pay_second_q, out_pay_third_q;

  logic   accept, in_range, query, out_free, load_out;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign in_range   = act_in_range(act_first_i) && act_in_range(act_second_i)
                   && act_in_range(act_third_i);
  assign query      = accept && (op_e'(op_i) == OP_QUERY);
  assign out_free   = !out_valid_q || out_ready_i;
  assign load_out   = (state_q == ST_LAST) && out_free;

  // write path goes straight to the memories
  assign mem_we_o    = accept && (op_e'(op_i) == OP_WRITE) && in_range;
  assign mem_waddr_o = cell_addr(act_idx(act_first_i), act_idx(act_second_i),
                                 act_idx(act_third_i));

  always_comb begin
    mem_re_o       = 1'b0;
    raddr_first_o  = cell_addr(x_q, y_q, z_q);
    raddr_second_o = cell_addr(x_q, y_q, z_q);
    raddr_third_o  = cell_addr(x_q, y_q, z_q);
    cmp_ctl_o      = '0;
    state_d        = state_q;
    cnt_d          = cnt_q;
    bad_d          = bad_q;
    case (state_q)
      ST_IDLE: begin
        if (query) begin
          cmp_ctl_o.clear = 1'b1;
          cnt_d           = '0;
          bad_d           = !in_range;
          state_d         = in_range ? ST_OWN : ST_LAST;
        end
      end
      ST_OWN: begin
        mem_re_o = 1'b1;
        state_d  = ST_DEV;
      end
      ST_DEV: begin
        mem_re_o           = 1'b1;
        raddr_first_o      = cell_addr(cnt_q, y_q, z_q);
        raddr_second_o     = cell_addr(x_q, cnt_q, z_q);
        raddr_third_o      = cell_addr(x_q, y_q, cnt_q);
        // first cycle sees the queried cell, later ones a deviation
        cmp_ctl_o.load_own = (cnt_q == '0);
        cmp_ctl_o.compare  = (cnt_q != '0);
        cnt_d              = cnt_q + 1'b1;
        if (cnt_q == IDX_W'(ACTIONS - 1)) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      bad_q       <= bad_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (query) begin
      x_q <= act_idx(act_first_i);
      y_q <= act_idx(act_second_i);
      z_q <= act_idx(act_third_i);
    end
    if (load_out) begin
      out_eq_q         <= !bad_q && cmp_eq_i;
      out_pay_first_q  <= bad_q ? '0 : own_first_i;
      out_pay_second_q <= bad_q ? '0 : own_second_i;
      out_pay_third_q  <= bad_q ? '0 : own_third_i;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_eq_o         = out_eq_q;
  assign out_pay_first_o  = out_pay_first_q;
  assign out_pay_second_o = out_pay_second_q;
  assign out_pay_third_o  = out_pay_third_q;

  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !mem_we_o)
    else $error("memory write while a query is in flight");

  a_dev_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DEV && cnt_q == IDX_W'(ACTIONS - 1)) |=> (state_q == ST_LAST))
    else $error("deviation sweep did not end on the last action");

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_LAST))
    else $error("result word raised outside the finishing step");

  a_bad_not_eq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && bad_q) |=> (!out_eq_q && out_pay_first_q == '0))
    else $error("out-of-range query reported as equilibrium");

endmodule

// ----- src/pure_nash_check_three_player.sv -----
// write word: no result word, next word taken in the following cycle
// query word: result registered after the own-cell read and the deviation sweep; next word
//   taken once the result is registered, which waits for a free result register; each
//   player's payoff memory is read once per cycle over the deviation sweep
// out-of-range query: result registered from the finishing step, with no sweep; a new word is
//   taken once the result is registered, also while it still waits on m_axis_tready
// reset clears control state only; payoff memories hold no defined value until written
module pure_nash_check_three_player
  import pnc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // act_first, act_second, act_third, pay_first, pay_second, pay_third, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // op
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // is_equilibrium, cell_pay_first, cell_pay_second, cell_pay_third, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned PAY0_LSB = 3 * ACT_W;
  localparam int unsigned PAY1_LSB = PAY0_LSB + PAY_W;
  localparam int unsigned PAY2_LSB = PAY1_LSB + PAY_W;
  localparam int unsigned OUT_PAD  = OUT_DATA_W - 1 - 3 * PAY_W;

  act_t     act_first, act_second, act_third;
  pay_t     pay_first, pay_second, pay_third;
  logic     mem_we, mem_re;
  addr_t    mem_waddr, raddr_first, raddr_second, raddr_third;
  pay_t     rd_first, rd_second, rd_third;
  pay_t     own_first, own_second, own_third;
  cmp_ctl_t cmp_ctl;
  logic     cmp_eq;
  logic     out_eq;
  pay_t     out_pay_first, out_pay_second, out_pay_third;

  assign act_first  = s_axis_tdata[ACT_W-1:0];
  assign act_second = s_axis_tdata[2*ACT_W-1:ACT_W];
  assign act_third  = s_axis_tdata[3*ACT_W-1:2*ACT_W];
  assign pay_first  = s_axis_tdata[PAY0_LSB +: PAY_W];
  assign pay_second = s_axis_tdata[PAY1_LSB +: PAY_W];
  assign pay_third  = s_axis_tdata[PAY2_LSB +: PAY_W];

  pnc_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .op_i             (s_axis_tuser),
    .act_first_i      (act_first),
    .act_second_i     (act_second),
    .act_third_i      (act_third),
    .mem_we_o         (mem_we),
    .mem_waddr_o      (mem_waddr),
    .mem_re_o         (mem_re),
    .raddr_first_o    (raddr_first),
    .raddr_second_o   (raddr_second),
    .raddr_third_o    (raddr_third),
    .cmp_ctl_o        (cmp_ctl),
    .cmp_eq_i         (cmp_eq),
    .own_first_i      (own_first),
    .own_second_i     (own_second),
    .own_third_i      (own_third),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_eq_o         (out_eq),
    .out_pay_first_o  (out_pay_first),
    .out_pay_second_o (out_pay_second),
    .out_pay_third_o  (out_pay_third)
  );

  pnc_ram u_ram_first (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (pay_first),
    .re_i    (mem_re),
    .raddr_i (raddr_first),
    .rdata_o (rd_first)
  );

  pnc_ram u_ram_second (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (pay_second),
    .re_i    (mem_re),
    .raddr_i (raddr_second),
    .rdata_o (rd_second)
  );

  pnc_ram u_ram_third (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (pay_third),
    .re_i    (mem_re),
    .raddr_i (raddr_third),
    .rdata_o (rd_third)
  );

  pnc_cmp u_cmp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (cmp_ctl),
    .rd_first_i   (rd_first),
    .rd_second_i  (rd_second),
    .rd_third_i   (rd_third),
    .own_first_o  (own_first),
    .own_second_o (own_second),
    .own_third_o  (own_third),
    .eq_o         (cmp_eq)
  );

  assign m_axis_tdata = {{OUT_PAD{1'b0}}, out_pay_third, out_pay_second, out_pay_first,
                         out_eq};

endmodule

// ----- tb/pure_nash_check_three_player_tb.sv -----
module pure_nash_check_three_player_tb;
  import pnc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned TAIL_CYCLES = ACTIONS + 8;
  localparam int unsigned RANDOM_WORDS = 560;

  typedef struct {
    logic eq;
    pay_t p0;
    pay_t p1;
    pay_t p2;
  } verdict_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  pay_t     payoff_tab [ACTIONS][ACTIONS][ACTIONS][3];
  verdict_t pending_verdicts [$];
  verdict_t want;
  bit       idle_on = 1'b1;
  int       error_count = 0;
  int       writes_sent = 0;
  int       queries_sent = 0;
  int       eq_predicted = 0;
  int       results_checked = 0;
  int       cycle_count = 0;

  pure_nash_check_three_player dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= !idle_on || ($urandom_range(0, 99) >= 7);
  end

  function automatic bit in_range(act_t x, act_t y, act_t z);
    return x < ACTIONS && y < ACTIONS && z < ACTIONS;
  endfunction

  // equilibrium verdict of one profile from the current payoff table
  function automatic verdict_t judge_profile(act_t x, act_t y, act_t z);
    verdict_t v;
    v = '{1'b0, '0, '0, '0};
    if (!in_range(x, y, z)) return v;
    v.eq = 1'b1;
    v.p0 = payoff_tab[x][y][z][0];
    v.p1 = payoff_tab[x][y][z][1];
    v.p2 = payoff_tab[x][y][z][2];
    for (int a = 0; a < ACTIONS; a++) begin
      if (payoff_tab[a][y][z][0] > v.p0) v.eq = 1'b0;
      if (payoff_tab[x][a][z][1] > v.p1) v.eq = 1'b0;
      if (payoff_tab[x][y][a][2] > v.p2) v.eq = 1'b0;
    end
    return v;
  endfunction

  function automatic pay_t rand_pay();
    case ($urandom_range(0, 3))
      0: return pay_t'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 32'sh0000_0000;
          default: return 32'shffff_ffff;
        endcase
      end
      // half steps from -3 to 3 so that ties come up often
      default: return pay_t'((int'($urandom_range(0, 12)) - 6) * 32'sh8000);
    endcase
  endfunction

  function automatic act_t rand_act();
    return act_t'($urandom_range(0, ACTIONS - 1));
  endfunction

  task automatic send_word(input op_e op, input act_t x, input act_t y, input act_t z,
                           input pay_t p0, input pay_t p1, input pay_t p2);
    verdict_t v;
    while (idle_on && $urandom_range(0, 99) < 7) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= IN_DATA_W'({p2, p1, p0, z, y, x});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (op == OP_WRITE) begin
      writes_sent++;
      if (in_range(x, y, z)) begin
        payoff_tab[x][y][z][0] = p0;
        payoff_tab[x][y][z][1] = p1;
        payoff_tab[x][y][z][2] = p2;
      end
    end else begin
      queries_sent++;
      v = judge_profile(x, y, z);
      if (v.eq) eq_predicted++;
      pending_verdicts.push_back(v);
    end
  endtask

  task automatic query(input act_t x, input act_t y, input act_t z);
    send_word(OP_QUERY, x, y, z, rand_pay(), rand_pay(), rand_pay());
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  // own payoffs set to the best deviation of each player (just above it when strict), then queried
  task automatic plant_equilibrium(input act_t x, input act_t y, input act_t z,
                                   input bit strict);
    pay_t best [3];
    for (int p = 0; p < 3; p++) best[p] = 32'sh8000_0000;
    for (int a = 0; a < ACTIONS; a++) begin
      if (a != x && payoff_tab[a][y][z][0] > best[0]) best[0] = payoff_tab[a][y][z][0];
      if (a != y && payoff_tab[x][a][z][1] > best[1]) best[1] = payoff_tab[x][a][z][1];
      if (a != z && payoff_tab[x][y][a][2] > best[2]) best[2] = payoff_tab[x][y][a][2];
    end
    for (int p = 0; p < 3; p++) begin
      if (strict && best[p] != 32'sh7fff_ffff) best[p] = best[p] + 1;
    end
    send_word(OP_WRITE, x, y, z, best[0], best[1], best[2]);
    query(x, y, z);
  endtask

  // one deviation of one player made just better than its own payoff (unless that is the maximum), then queried
  task automatic break_by_player(input act_t x, input act_t y, input act_t z, input int p);
    act_t d [3];
    act_t own;
    pay_t dev_pay [3];
    d[0] = x;
    d[1] = y;
    d[2] = z;
    own = d[p];
    do d[p] = rand_act(); while (d[p] == own);
    for (int i = 0; i < 3; i++) dev_pay[i] = payoff_tab[d[0]][d[1]][d[2]][i];
    if (payoff_tab[x][y][z][p] != 32'sh7fff_ffff) begin
      dev_pay[p] = payoff_tab[x][y][z][p] + 1;
      send_word(OP_WRITE, d[0], d[1], d[2], dev_pay[0], dev_pay[1], dev_pay[2]);
    end
    query(x, y, z);
  endtask

  task automatic check_field(input string name, input logic [PAY_W-1:0] exp_val,
                             input logic [PAY_W-1:0] got_val);
    if (exp_val !== got_val) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, got_val);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: result word with nothing pending, expected none, actual %h",
                 $time, m_axis_tdata);
        error_count++;
      end else begin
        want = pending_verdicts.pop_front();
        results_checked++;
        check_field("is_equilibrium", PAY_W'(want.eq), PAY_W'(m_axis_tdata[0]));
        check_field("cell_pay_first", want.p0, m_axis_tdata[PAY_W:1]);
        check_field("cell_pay_second", want.p1, m_axis_tdata[2*PAY_W:PAY_W+1]);
        check_field("cell_pay_third", want.p2, m_axis_tdata[3*PAY_W:2*PAY_W+1]);
      end
    end
  end

  task automatic test_fill_table();
    for (int a = 0; a < ACTIONS; a++) begin
      for (int b = 0; b < ACTIONS; b++) begin
        for (int c = 0; c < ACTIONS; c++) begin
          send_word(OP_WRITE, act_t'(a), act_t'(b), act_t'(c),
                    rand_pay(), rand_pay(), rand_pay());
        end
      end
    end
  endtask

  task automatic test_directed();
    act_t hi;
    act_t mid;
    hi  = act_t'(ACTIONS - 1);
    mid = act_t'(ACTIONS / 2);
    query('0, '0, '0);
    query(hi, hi, hi);
    send_word(OP_WRITE, '0, '0, '0, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    query('0, '0, '0);
    send_word(OP_WRITE, hi, hi, hi, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    query(hi, hi, hi);
    send_word(OP_WRITE, '0, hi, '0, 32'sh0000_0000, 32'shffff_ffff, 32'sh7fff_ffff);
    query('0, hi, '0);
    send_word(OP_WRITE, hi, '0, mid, 32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa);
    query(hi, '0, mid);
    send_word(OP_WRITE, mid, hi, '0, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555);
    query(mid, hi, '0);
    // ties with the best deviation still count as equilibrium
    plant_equilibrium(mid, '0, hi, 1'b0);
    plant_equilibrium(act_t'(1), mid, act_t'(1), 1'b1);
    for (int p = 0; p < 3; p++) begin
      plant_equilibrium(mid, mid, mid, 1'b0);
      break_by_player(mid, mid, mid, p);
    end
  endtask

  task automatic test_random_mix();
    int start;
    int n;
    start = writes_sent + queries_sent;
    n = 0;
    while (n < RANDOM_WORDS) begin
      // a long stretch with both sides always ready
      idle_on = !(n >= 150 && n < 300);
      if (n >= 400 && n < 404) wait_for_results();
      case ($urandom_range(0, 9))
        0, 1, 2, 3:
          send_word(OP_WRITE, act_t'($urandom_range(0, 7)), act_t'($urandom_range(0, 7)),
                    act_t'($urandom_range(0, 7)), rand_pay(), rand_pay(), rand_pay());
        4, 5, 6:
          query(act_t'($urandom_range(0, 7)), act_t'($urandom_range(0, 7)),
                act_t'($urandom_range(0, 7)));
        7, 8:
          plant_equilibrium(rand_act(), rand_act(), rand_act(), $urandom_range(0, 1));
        default:
          break_by_player(rand_act(), rand_act(), rand_act(), $urandom_range(0, 2));
      endcase
      n = writes_sent + queries_sent - start;
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= OP_WRITE;
    s_axis_tdata  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill_table();
    test_directed();
    wait_for_results();
    test_random_mix();
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("covered %0d write words and %0d query words, %0d predicted equilibria",
             writes_sent, queries_sent, eq_predicted);
    $display("%0d result words compared with the predicted verdicts", results_checked);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
